### design/psmm_pkg.sv
package psmm_pkg;

  localparam int FLOW_W     = 14;
  localparam int OFFS_W     = 10;
  localparam int CMD_W      = 24;
  localparam int WIN_W      = 2;
  localparam int P2P_W      = 14;
  localparam int POW_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TFLOW_W    = 13;
  localparam int MAXPOW_W   = 15;
  localparam int GAIN_W     = 16;

  localparam int DIFF_W     = 18;
  localparam int MUL_W      = 27;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int TERM_W     = 35;
  localparam int RND_W      = TERM_W + 1;
  localparam int U_W        = 25;
  localparam int Q_W        = 17;

  // floor(u / 250) == (u * RECIP_M) >> RECIP_SHIFT for every u below 2**U_W
  localparam logic [25:0]    RECIP_M     = 26'd34359739;
  localparam int             RECIP_SHIFT = 33;
  // u = 3*t + 125 + 250*POW_BIAS keeps the dividend positive
  localparam logic [MUL_W-1:0] U_BIAS    = 27'd10625125;
  localparam logic [Q_W:0]   POW_BIAS    = 18'd42500;

  localparam logic signed [CMD_W-1:0] CMD_MAX = 24'sh7FFFFF;
  localparam logic signed [CMD_W-1:0] CMD_MIN = 24'sh800000;
  localparam logic signed [RND_W-1:0] RND_HALF = 36'sd128;

  localparam logic [TFLOW_W-1:0]  RST_TARGET_FLOW = 13'd1280;
  localparam logic [TFLOW_W-1:0]  RST_MIN_FLOW    = 13'd768;
  localparam logic [MAXPOW_W-1:0] RST_MAX_POWER   = 15'd12288;
  localparam logic [TFLOW_W-1:0]  RST_TARGET_P2P  = 13'd512;
  localparam logic [GAIN_W-1:0]   RST_FLOW_GAIN   = 16'd6400;
  localparam logic [GAIN_W-1:0]   RST_POWER_GAIN  = 16'd1333;
  localparam logic [GAIN_W-1:0]   RST_P2P_GAIN    = 16'd9600;
  localparam logic [GAIN_W-1:0]   RST_FLOOR_GAIN  = 16'd12800;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_FLOW,
    CFG_MIN_FLOW,
    CFG_MAX_POWER,
    CFG_TARGET_P2P,
    CFG_FLOW_GAIN,
    CFG_POWER_GAIN,
    CFG_P2P_GAIN,
    CFG_FLOOR_GAIN
  } cfg_reg_e;

  typedef enum logic [WIN_W-1:0] {
    WIN_FLOW,
    WIN_POWER,
    WIN_P2P,
    WIN_FLOOR
  } win_term_e;

  typedef enum logic [2:0] {
    MUL_RECIP,
    MUL_FLOW,
    MUL_FLOOR,
    MUL_POWER,
    MUL_P2P
  } mul_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECIP,
    ST_FLOW,
    ST_FLOOR,
    ST_POWER,
    ST_P2P,
    ST_SELECT,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     cap_power;
    logic     cap_flow;
    logic     cap_floor;
    logic     cap_pow;
    logic     do_select;
    logic     write_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

### design/psmm_in_if.sv
interface psmm_in_if import psmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [FLOW_W-1:0] flow_sample;
  logic [OFFS_W-1:0]        speed_offset;

  modport source (output valid, flow_sample, speed_offset, input ready);
  modport sink   (input valid, flow_sample, speed_offset, output ready);
endinterface

### design/psmm_out_if.sv
interface psmm_out_if import psmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CMD_W-1:0]  speed_command;
  logic [WIN_W-1:0]         winning_term;
  logic [P2P_W-1:0]         p2p_estimate;
  logic signed [POW_W-1:0]  power_estimate;

  modport source (output valid, speed_command, winning_term, p2p_estimate, power_estimate,
                  input ready);
  modport sink   (input valid, speed_command, winning_term, p2p_estimate, power_estimate,
                  output ready);
endinterface

### design/psmm_cfg_if.sv
interface psmm_cfg_if import psmm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### design/psmm_ctrl.sv
module psmm_ctrl import psmm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_RECIP;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_RECIP;
        end
      end
      ST_RECIP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RECIP;
        state_d       = ST_FLOW;
      end
      ST_FLOW: begin
        cmd_o.cap_power = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_FLOW;
        state_d         = ST_FLOOR;
      end
      ST_FLOOR: begin
        cmd_o.cap_flow = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_FLOOR;
        state_d        = ST_POWER;
      end
      ST_POWER: begin
        cmd_o.cap_floor = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_POWER;
        state_d         = ST_P2P;
      end
      ST_P2P: begin
        cmd_o.cap_pow = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P2P;
        state_d       = ST_SELECT;
      end
      ST_SELECT: begin
        cmd_o.do_select = 1'b1;
        state_d         = ST_WRITE;
      end
      ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.write_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_RECIP))
    else $error("accepted request did not start the multiply sequence");

  a_write_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write_out |=> (state_q == ST_IDLE))
    else $error("result write did not return to idle");

endmodule

### design/psmm_dp.sv
module psmm_dp import psmm_pkg::*; #(
  parameter int WINDOW_LEN = 31
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [FLOW_W-1:0] flow_i,
  input  logic [OFFS_W-1:0]        offset_i,
  input  logic                     cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     out_ready_i,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  output logic                     out_valid_o,
  output logic signed [CMD_W-1:0]  speed_command_o,
  output logic [WIN_W-1:0]         winning_term_o,
  output logic [P2P_W-1:0]         p2p_o,
  output logic signed [POW_W-1:0]  power_o
);

  localparam int WC_W = (WINDOW_LEN > 2) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [WC_W-1:0] WC_LAST = WC_W'(WINDOW_LEN - 1);
  localparam logic [WC_W-1:0] WC_ONE  = WC_W'(1);

  // configuration
  logic [TFLOW_W-1:0]  target_flow_q, min_flow_q, target_p2p_q;
  logic [MAXPOW_W-1:0] max_power_q;
  logic [GAIN_W-1:0]   flow_gain_q, power_gain_q, p2p_gain_q, floor_gain_q;

  // per-sample history
  logic signed [FLOW_W-1:0] prev_q, peak_hi_q, peak_lo_q;
  logic                     hi_valid_q, lo_valid_q;
  logic [P2P_W-1:0]         puls_q;
  logic [WC_W-1:0]          wc_q;

  logic signed [FLOW_W-1:0] peak_hi_d, peak_lo_d;
  logic                     hi_valid_d, lo_valid_d, rising;
  logic [P2P_W-1:0]         puls_d;
  logic signed [FLOW_W:0]   peak_diff;

  // working registers
  logic signed [FLOW_W-1:0] flow_q;
  logic [U_W-1:0]           u_q;
  logic signed [POW_W-1:0]  power_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [TERM_W-1:0] tflow_q, tfloor_q, tpow_q, chosen_q;
  logic [WIN_W-1:0]         win_q;

  logic signed [MUL_W-1:0]  f_ext, off_ext, t_lin, u_calc;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [DIFF_W-1:0] diff;
  logic [GAIN_W-1:0]        gain;
  logic [Q_W-1:0]           quot;
  logic signed [Q_W:0]      power_calc;
  logic signed [TERM_W-1:0] tp2p, min_term, chosen_d;
  logic [WIN_W-1:0]         min_win, win_d;
  logic signed [RND_W-1:0]  rnd, rnd_sh;
  logic signed [CMD_W-1:0]  cmd_sat;

  logic                     out_valid_q;
  logic signed [CMD_W-1:0]  cmd_out_q;
  logic [WIN_W-1:0]         win_out_q;
  logic [P2P_W-1:0]         p2p_out_q;
  logic signed [POW_W-1:0]  pow_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_flow_q <= RST_TARGET_FLOW;
      min_flow_q    <= RST_MIN_FLOW;
      max_power_q   <= RST_MAX_POWER;
      target_p2p_q  <= RST_TARGET_P2P;
      flow_gain_q   <= RST_FLOW_GAIN;
      power_gain_q  <= RST_POWER_GAIN;
      p2p_gain_q    <= RST_P2P_GAIN;
      floor_gain_q  <= RST_FLOOR_GAIN;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TARGET_FLOW: target_flow_q <= cfg_data_i[TFLOW_W-1:0];
        CFG_MIN_FLOW:    min_flow_q    <= cfg_data_i[TFLOW_W-1:0];
        CFG_MAX_POWER:   max_power_q   <= cfg_data_i[MAXPOW_W-1:0];
        CFG_TARGET_P2P:  target_p2p_q  <= cfg_data_i[TFLOW_W-1:0];
        CFG_FLOW_GAIN:   flow_gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_POWER_GAIN:  power_gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_P2P_GAIN:    p2p_gain_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_FLOOR_GAIN:  floor_gain_q  <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // peak tracking, window restart clears both valids
  always_comb begin
    rising     = flow_i > prev_q;
    peak_hi_d  = rising ? flow_i : peak_hi_q;
    peak_lo_d  = rising ? peak_lo_q : flow_i;
    hi_valid_d = (rising || hi_valid_q) && (wc_q != '0);
    lo_valid_d = (!rising || lo_valid_q) && (wc_q != '0);
    peak_diff  = (FLOW_W+1)'(peak_hi_d) - (FLOW_W+1)'(peak_lo_d);
    puls_d     = puls_q;
    if (hi_valid_d && lo_valid_d) begin
      puls_d = peak_diff[FLOW_W] ? '0 : peak_diff[P2P_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      peak_hi_q  <= '0;
      peak_lo_q  <= '0;
      hi_valid_q <= 1'b0;
      lo_valid_q <= 1'b0;
      puls_q     <= '0;
      wc_q       <= '0;
    end else if (cmd_i.accept) begin
      prev_q     <= flow_i;
      peak_hi_q  <= peak_hi_d;
      peak_lo_q  <= peak_lo_d;
      hi_valid_q <= hi_valid_d;
      lo_valid_q <= lo_valid_d;
      puls_q     <= puls_d;
      wc_q       <= (wc_q == WC_LAST) ? '0 : wc_q + WC_ONE;
    end
  end

  // u = 3*(400*flow - 256*offset) + bias, always positive
  always_comb begin
    f_ext   = MUL_W'(flow_i);
    off_ext = $signed(MUL_W'(offset_i));
    t_lin   = (f_ext <<< 8) + (f_ext <<< 7) + (f_ext <<< 4) - (off_ext <<< 8);
    u_calc  = (t_lin <<< 1) + t_lin + $signed(U_BIAS);
  end

  always_comb begin
    diff = '0;
    gain = '0;
    unique case (cmd_i.mul_sel)
      MUL_RECIP: begin
        diff = '0;
        gain = '0;
      end
      MUL_FLOW: begin
        diff = $signed(DIFF_W'(target_flow_q)) - DIFF_W'(flow_q);
        gain = flow_gain_q;
      end
      MUL_FLOOR: begin
        diff = DIFF_W'(flow_q) - $signed(DIFF_W'(min_flow_q));
        gain = floor_gain_q;
      end
      MUL_POWER: begin
        diff = $signed(DIFF_W'(max_power_q)) - DIFF_W'(power_q);
        gain = power_gain_q;
      end
      MUL_P2P: begin
        diff = $signed(DIFF_W'(puls_q)) - $signed(DIFF_W'(target_p2p_q));
        gain = p2p_gain_q;
      end
      default: begin
        diff = '0;
        gain = '0;
      end
    endcase
    if (cmd_i.mul_sel == MUL_RECIP) begin
      mul_a = $signed(MUL_W'(u_q));
      mul_b = $signed(MUL_W'(RECIP_M));
    end else begin
      mul_a = MUL_W'(diff);
      mul_b = $signed(MUL_W'(gain));
    end
  end

  assign quot       = prod_q[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
  assign power_calc = $signed({1'b0, quot}) - $signed(POW_BIAS);
  assign tp2p       = $signed(prod_q[TERM_W-1:0]);

  // strict minimum, ties to pulsatility; floor wins only when strictly larger
  always_comb begin
    priority if (tflow_q < tpow_q && tflow_q < tp2p) begin
      min_term = tflow_q;
      min_win  = WIN_FLOW;
    end else if (tpow_q < tflow_q && tpow_q < tp2p) begin
      min_term = tpow_q;
      min_win  = WIN_POWER;
    end else begin
      min_term = tp2p;
      min_win  = WIN_P2P;
    end
    if (tfloor_q > min_term) begin
      chosen_d = tfloor_q;
      win_d    = WIN_FLOOR;
    end else begin
      chosen_d = min_term;
      win_d    = min_win;
    end
  end

  always_comb begin
    rnd    = RND_W'(chosen_q) + RND_HALF;
    rnd_sh = rnd >>> 8;
    priority if (rnd_sh > RND_W'(CMD_MAX)) begin
      cmd_sat = CMD_MAX;
    end else if (rnd_sh < RND_W'(CMD_MIN)) begin
      cmd_sat = CMD_MIN;
    end else begin
      cmd_sat = rnd_sh[CMD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      flow_q <= flow_i;
      u_q    <= u_calc[U_W-1:0];
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.cap_power) begin
      power_q <= power_calc[POW_W-1:0];
    end
    if (cmd_i.cap_flow) begin
      tflow_q <= $signed(prod_q[TERM_W-1:0]);
    end
    if (cmd_i.cap_floor) begin
      tfloor_q <= $signed(prod_q[TERM_W-1:0]);
    end
    if (cmd_i.cap_pow) begin
      tpow_q <= $signed(prod_q[TERM_W-1:0]);
    end
    if (cmd_i.do_select) begin
      chosen_q <= chosen_d;
      win_q    <= win_d;
    end
    if (cmd_i.write_out) begin
      cmd_out_q <= cmd_sat;
      win_out_q <= win_q;
      p2p_out_q <= puls_q;
      pow_out_q <= power_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign speed_command_o   = cmd_out_q;
  assign winning_term_o    = win_out_q;
  assign p2p_o             = p2p_out_q;
  assign power_o           = pow_out_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= WC_LAST)
    else $error("window counter past its last sample");

  a_window_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wc_q == WC_ONE && WINDOW_LEN > 1) |-> !(hi_valid_q && lo_valid_q))
    else $error("peaks still both valid straight after window restart");

endmodule

### design/pump_speed_minmax_controller.sv
// Min/max proportional pump speed controller. One flow request in, one result out: the
// result of a sample is written to the output register once its request has been accepted
// and processed, provided the output register is free by then. The processing is five passes
// through the single shared 27x27 multiplier (the power reciprocal and the four proportional
// terms), then term selection, then rounding and the output write. The block takes a new
// request on the cycle after the write, so it does not accept a request while one is in
// progress. A new request is taken once the previous result is in the output register, even
// if it has not been collected yet. The write of that next result waits until the output
// register is empty or being taken. Peak tracking restarts every WINDOW_LEN samples.
// Configuration writes are always ready and must only be issued while the block is idle.
module pump_speed_minmax_controller import psmm_pkg::*; #(
  parameter int WINDOW_LEN = 31
) (
  input logic        clk_i,
  input logic        rst_ni,
  psmm_in_if.sink    in_i,
  psmm_out_if.source out_o,
  psmm_cfg_if.sink   cfg_i
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  psmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  psmm_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .flow_i          (in_i.flow_sample),
    .offset_i        (in_i.speed_offset),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.reg_index),
    .cfg_data_i      (cfg_i.wdata),
    .out_ready_i     (out_o.ready),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_o.valid),
    .speed_command_o (out_o.speed_command),
    .winning_term_o  (out_o.winning_term),
    .p2p_o           (out_o.p2p_estimate),
    .power_o         (out_o.power_estimate)
  );

endmodule
